// File: sv/bums_pkg.sv
// shared constants and controller/datapath interface types for the merge sorter
package bums_pkg;

  localparam int MAX_ITEMS  = 64;
  localparam int VALUE_BITS = 32;
  localparam int IDX_BITS   = $clog2(MAX_ITEMS);
  localparam int CNT_BITS   = $clog2(MAX_ITEMS + 1);
  // pointer sums reach almost three times the capacity
  localparam int PTR_BITS   = CNT_BITS + 2;

  typedef struct packed {
    logic load;
    logic sort_start;
    logic pass_start;
    logic merge;
    logic emit_start;
    logic emit;
    logic clear_batch;
  } bums_cmd_t;

  typedef struct packed {
    logic multi;
    logic last_write;
    logic w2_ge_n;
    logic emit_last;
  } bums_sts_t;

endpackage

// File: sv/bums_datapath.sv
// datapath: batch memories, merge pointers, signed compare and output register
module bums_datapath import bums_pkg::*; (
  input  logic                  clk,
  input  logic                  rst,
  input  bums_cmd_t             cmd,
  output bums_sts_t             sts,
  input  logic [VALUE_BITS-1:0] value,
  input  logic                  out_ready,
  output logic                  out_valid,
  output logic [VALUE_BITS-1:0] sorted_value,
  output logic                  final_item,
  output logic                  overflowed
);

  logic [VALUE_BITS-1:0] mem0 [MAX_ITEMS];
  logic [VALUE_BITS-1:0] mem1 [MAX_ITEMS];
  logic [VALUE_BITS-1:0] rd0a, rd0b, rd1a, rd1b;

  logic [CNT_BITS-1:0] count;
  logic                ovf;
  logic                src;
  logic [PTR_BITS-1:0] width, left, pa, pb, k, optr;
  logic [PTR_BITS-1:0] pa_next, pb_next, optr_next;

  logic [PTR_BITS-1:0] n;
  logic [PTR_BITS-1:0] sum_a, sum_b, a_end, b_end, k_inc, o_inc;
  logic [VALUE_BITS-1:0] head_a, head_b, merge_data;
  logic a_ok, b_ok, take_b, pair_end, last_write, load_out, not_full;
  logic [IDX_BITS-1:0] addr_a, addr_b;

  assign n        = PTR_BITS'(count);
  assign not_full = count < CNT_BITS'(MAX_ITEMS);

  assign head_a = src ? rd1a : rd0a;
  assign head_b = src ? rd1b : rd0b;

  // run bounds of the current pair, clipped to the batch size
  assign sum_a = left + width;
  assign sum_b = sum_a + width;
  assign a_end = (sum_a < n) ? sum_a : n;
  assign b_end = (sum_b < n) ? sum_b : n;
  assign a_ok  = pa < a_end;
  assign b_ok  = pb < b_end;

  // left run wins ties so the merge stays stable
  assign take_b     = b_ok && (!a_ok || ($signed(head_b) < $signed(head_a)));
  assign merge_data = take_b ? head_b : head_a;
  assign k_inc      = k + PTR_BITS'(1);
  assign pair_end   = k_inc == b_end;
  assign last_write = k_inc == n;

  assign o_inc    = optr + PTR_BITS'(1);
  assign load_out = cmd.emit && (optr < n) && (!out_valid || out_ready);

  always_comb begin
    pa_next = pa;
    pb_next = pb;
    if (cmd.pass_start) begin
      pa_next = '0;
      pb_next = width;
    end else if (cmd.merge) begin
      if (pair_end) begin
        pa_next = sum_b;
        pb_next = sum_b + width;
      end else if (take_b) begin
        pb_next = pb + PTR_BITS'(1);
      end else begin
        pa_next = pa + PTR_BITS'(1);
      end
    end
  end

  always_comb begin
    optr_next = optr;
    if (cmd.emit_start) begin
      optr_next = '0;
    end else if (load_out) begin
      optr_next = o_inc;
    end
  end

  // read addresses follow the updated pointers so read data lines up next cycle
  assign addr_a = (cmd.emit || cmd.emit_start) ? optr_next[IDX_BITS-1:0]
                                               : pa_next[IDX_BITS-1:0];
  assign addr_b = pb_next[IDX_BITS-1:0];

  always_ff @(posedge clk) begin
    if (cmd.load && not_full) begin
      mem0[count[IDX_BITS-1:0]] <= value;
    end else if (cmd.merge && src) begin
      mem0[k[IDX_BITS-1:0]] <= merge_data;
    end
    rd0a <= mem0[addr_a];
    rd0b <= mem0[addr_b];
  end

  always_ff @(posedge clk) begin
    if (cmd.merge && !src) begin
      mem1[k[IDX_BITS-1:0]] <= merge_data;
    end
    rd1a <= mem1[addr_a];
    rd1b <= mem1[addr_b];
  end

  always_ff @(posedge clk) begin
    pa   <= pa_next;
    pb   <= pb_next;
    optr <= optr_next;
    if (cmd.pass_start) begin
      left <= '0;
      k    <= '0;
    end else if (cmd.merge) begin
      k <= k_inc;
      if (pair_end) begin
        left <= sum_b;
      end
    end
    if (cmd.sort_start) begin
      width <= PTR_BITS'(1);
      src   <= 1'b0;
    end else if (cmd.merge && last_write) begin
      width <= width << 1;
      src   <= ~src;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
      ovf   <= 1'b0;
    end else if (cmd.clear_batch) begin
      count <= '0;
      ovf   <= 1'b0;
    end else if (cmd.load) begin
      if (not_full) begin
        count <= count + CNT_BITS'(1);
      end else begin
        ovf <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load_out) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      sorted_value <= head_a;
      final_item   <= o_inc == n;
      overflowed   <= ovf;
    end
  end

  assign sts.multi      = count != '0;
  assign sts.last_write = last_write;
  assign sts.w2_ge_n    = (width << 1) >= n;
  assign sts.emit_last  = load_out && (o_inc == n);

endmodule

// File: sv/bums_ctrl.sv
// controller state machine: load, merge passes, emit
module bums_ctrl import bums_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  logic      in_valid,
  input  logic      batch_end,
  input  bums_sts_t sts,
  output logic      in_ready,
  output bums_cmd_t cmd
);

  typedef enum logic [4:0] {
    ST_LOAD   = 5'b00001,
    ST_MPRIME = 5'b00010,
    ST_MERGE  = 5'b00100,
    ST_OPRIME = 5'b01000,
    ST_EMIT   = 5'b10000
  } state_t;

  state_t state, state_next;

  assign in_ready = state == ST_LOAD;

  always_comb begin
    cmd        = '0;
    state_next = state;
    unique case (state)
      ST_LOAD: begin
        cmd.load = in_valid;
        if (in_valid && batch_end) begin
          cmd.sort_start = 1'b1;
          // a single item needs no merging
          state_next = sts.multi ? ST_MPRIME : ST_OPRIME;
        end
      end
      ST_MPRIME: begin
        cmd.pass_start = 1'b1;
        state_next     = ST_MERGE;
      end
      ST_MERGE: begin
        cmd.merge = 1'b1;
        if (sts.last_write) begin
          state_next = sts.w2_ge_n ? ST_OPRIME : ST_MPRIME;
        end
      end
      ST_OPRIME: begin
        cmd.emit_start = 1'b1;
        state_next     = ST_EMIT;
      end
      ST_EMIT: begin
        cmd.emit = 1'b1;
        if (sts.emit_last) begin
          cmd.clear_batch = 1'b1;
          state_next      = ST_LOAD;
        end
      end
      default: begin
        state_next = ST_LOAD;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_LOAD;
    end else begin
      state <= state_next;
    end
  end

endmodule

// File: sv/bottom_up_merge_sort.sv
// top level of the bottom-up merge sorter: controller, datapath and checks
// Usage: values enter on the in channel (in_valid/in_ready), one per transaction,
// up to 64 per batch; the transaction with batch_end set closes the batch.
// Values beyond 64 are dropped and every result of that batch has overflowed set.
// Sorted values leave ascending on the out channel (out_valid/out_ready),
// final_item marks the last one; a one-value batch comes back unchanged.
// Timing for a batch of n values: the values load, then ceil(log2 n) merge
// passes follow, each a read-priming state (ST_MPRIME) and then one value
// written per cycle; a priming state (ST_OPRIME) comes before output, then
// one result per cycle while the receiver takes them. Merge speed is bound
// by the single write port of the merge memories.
// in_ready is high only while a batch is loading; it returns once the last
// result sits in the output register, so the next batch can load while that
// result waits. When the receiver stalls, results hold and emission pauses.
// Reset (rst, synchronous) empties the batch and the output register; the
// memories need no clearing.
module bottom_up_merge_sort import bums_pkg::*; (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  logic [VALUE_BITS-1:0] value,
  input  logic                  batch_end,
  output logic                  out_valid,
  input  logic                  out_ready,
  output logic [VALUE_BITS-1:0] sorted_value,
  output logic                  final_item,
  output logic                  overflowed
);

  bums_cmd_t cmd;
  bums_sts_t sts;

  bums_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .batch_end (batch_end),
    .sts       (sts),
    .in_ready  (in_ready),
    .cmd       (cmd)
  );

  bums_datapath u_dp (
    .clk          (clk),
    .rst          (rst),
    .cmd          (cmd),
    .sts          (sts),
    .value        (value),
    .out_ready    (out_ready),
    .out_valid    (out_valid),
    .sorted_value (sorted_value),
    .final_item   (final_item),
    .overflowed   (overflowed)
  );

  // closing a batch stops loading
  a_close_busy: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready && batch_end |=> !in_ready)
    else $error("input taken right after batch close");

  // a finished pass is followed by a priming cycle
  a_pass_prime: assert property (@(posedge clk) disable iff (rst)
    cmd.merge && sts.last_write |=> cmd.pass_start || cmd.emit_start)
    else $error("no priming cycle after merge pass");

  // last result handed over returns the block to loading
  a_emit_done: assert property (@(posedge clk) disable iff (rst)
    cmd.emit && sts.emit_last |=> in_ready)
    else $error("block not loading after last result");

  // loading and merging never overlap
  a_no_merge_load: assert property (@(posedge clk) disable iff (rst)
    in_ready |-> !cmd.merge && !cmd.emit)
    else $error("merge or emit while loading");

endmodule

// File: sim/tb_bottom_up_merge_sort.sv
// testbench for bottom_up_merge_sort: directed and random batches checked against a sort predictor
`timescale 1ns / 100ps

module tb_bottom_up_merge_sort;
  import bums_pkg::*;

  localparam int RAND_ITEMS   = 180;
  localparam int LIMIT_CYCLES = 400000;
  localparam int DIR_ROWS     = 25;

  typedef struct packed {
    logic signed [VALUE_BITS-1:0] val;
    logic                         last;
    logic                         ovf;
  } sort_result_t;

  // one table row sends val reps times; batch_end goes on the final copy only
  typedef struct packed {
    logic [VALUE_BITS-1:0] val;
    logic                  last;
    logic [7:0]            reps;
    logic                  typed;
    logic [VALUE_BITS-1:0] want;
  } stim_row_t;

  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic                  in_valid = 1'b0;
  logic                  in_ready;
  logic [VALUE_BITS-1:0] value = '0;
  logic                  batch_end = 1'b0;
  logic                  out_valid;
  logic                  out_ready = 1'b0;
  logic [VALUE_BITS-1:0] sorted_value;
  logic                  final_item;
  logic                  overflowed;

  sort_result_t                 sorted_q[$];
  logic signed [VALUE_BITS-1:0] batch_vals [MAX_ITEMS];
  int unsigned                  batch_count = 0;
  logic                         batch_dropped = 1'b0;
  int                           mismatch_count = 0;
  int                           send_idle_pct = 0;
  int                           recv_stall_pct = 0;
  int                           cycle_count = 0;

  // typed rows are single-value batches, so the echo is read off directly
  stim_row_t directed_rows [DIR_ROWS] = '{
    '{32'h8000_0000, 1'b1, 8'd1,  1'b1, 32'h8000_0000},
    '{32'h7fff_ffff, 1'b1, 8'd1,  1'b1, 32'h7fff_ffff},
    '{32'h0000_0000, 1'b1, 8'd1,  1'b1, 32'h0000_0000},
    '{32'hffff_ffff, 1'b1, 8'd1,  1'b1, 32'hffff_ffff},
    '{32'haaaa_aaaa, 1'b1, 8'd1,  1'b1, 32'haaaa_aaaa},
    '{32'h5555_5555, 1'b1, 8'd1,  1'b1, 32'h5555_5555},
    '{32'h7fff_ffff, 1'b0, 8'd1,  1'b0, 32'h0},
    '{32'h8000_0000, 1'b0, 8'd1,  1'b0, 32'h0},
    '{32'h0000_0000, 1'b0, 8'd1,  1'b0, 32'h0},
    '{32'hffff_ffff, 1'b0, 8'd1,  1'b0, 32'h0},
    '{32'h0000_0001, 1'b1, 8'd1,  1'b0, 32'h0},
    '{32'h0000_0005, 1'b0, 8'd1,  1'b0, 32'h0},
    '{32'hffff_fffb, 1'b0, 8'd1,  1'b0, 32'h0},
    '{32'h0000_0005, 1'b0, 8'd1,  1'b0, 32'h0},
    '{32'hffff_fffb, 1'b1, 8'd1,  1'b0, 32'h0},
    '{32'h0000_0003, 1'b0, 8'd1,  1'b0, 32'h0},
    '{32'h0000_0002, 1'b0, 8'd1,  1'b0, 32'h0},
    '{32'h0000_0001, 1'b1, 8'd1,  1'b0, 32'h0},
    // exactly full, no drop
    '{32'h1234_5678, 1'b0, 8'd63, 1'b0, 32'h0},
    '{32'h8000_0000, 1'b1, 8'd1,  1'b0, 32'h0},
    // full store meets the batch_end value, which is dropped
    '{32'h7fff_ffff, 1'b0, 8'd64, 1'b0, 32'h0},
    '{32'h0000_0000, 1'b1, 8'd1,  1'b0, 32'h0},
    // several dropped values before the close
    '{32'hffff_ffff, 1'b0, 8'd60, 1'b0, 32'h0},
    '{32'h0000_0001, 1'b0, 8'd10, 1'b0, 32'h0},
    '{32'h8000_0000, 1'b1, 8'd1,  1'b0, 32'h0}
  };

  bottom_up_merge_sort uut (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .value        (value),
    .batch_end    (batch_end),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .sorted_value (sorted_value),
    .final_item   (final_item),
    .overflowed   (overflowed)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // stores the value, and on batch close queues the batch in ascending order
  function automatic void predict_sorted(input logic [VALUE_BITS-1:0] v, input logic e);
    logic signed [VALUE_BITS-1:0] key;
    int                           i;
    int                           j;
    sort_result_t                 r;
    if (batch_count < MAX_ITEMS) begin
      batch_vals[batch_count] = v;
      batch_count++;
    end else begin
      batch_dropped = 1'b1;
    end
    if (e) begin
      // stable insertion sort; equal keys carry nothing to tell them apart
      for (i = 1; i < int'(batch_count); i++) begin
        key = batch_vals[i];
        j = i - 1;
        while (j >= 0 && batch_vals[j] > key) begin
          batch_vals[j+1] = batch_vals[j];
          j--;
        end
        batch_vals[j+1] = key;
      end
      for (i = 0; i < int'(batch_count); i++) begin
        r.val  = batch_vals[i];
        r.last = (i == int'(batch_count) - 1);
        r.ovf  = batch_dropped;
        sorted_q.push_back(r);
      end
      batch_count   = 0;
      batch_dropped = 1'b0;
    end
  endfunction

  // holds valid and payload until the transaction is taken
  task automatic send_value(input logic [VALUE_BITS-1:0] v, input logic e);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid  <= 1'b1;
    value     <= v;
    batch_end <= e;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
  endtask

  function automatic logic [VALUE_BITS-1:0] pick_value();
    logic [VALUE_BITS-1:0] v;
    case ($urandom_range(9))
      0: v = 32'h8000_0000;
      1: v = 32'h7fff_ffff;
      2: v = '0;
      3: v = '1;
      4, 5: v = VALUE_BITS'($signed($urandom_range(8)) - 4);
      default: v = $urandom;
    endcase
    return v;
  endfunction

  always @(posedge clk) begin
    out_ready <= ($urandom_range(99) >= recv_stall_pct);
  end

  always @(posedge clk) begin
    sort_result_t exp_r;
    if (!rst && out_valid && out_ready) begin
      if (sorted_q.size() == 0) begin
        mismatch_count++;
        $display("%0t: result with nothing expected, sorted_value actual %0d", $time,
                 $signed(sorted_value));
      end else begin
        exp_r = sorted_q.pop_front();
        if (sorted_value !== exp_r.val) begin
          mismatch_count++;
          $display("%0t: sorted_value expected %0d actual %0d", $time, exp_r.val,
                   $signed(sorted_value));
        end
        if (final_item !== exp_r.last) begin
          mismatch_count++;
          $display("%0t: final_item expected %0b actual %0b", $time, exp_r.last,
                   final_item);
        end
        if (overflowed !== exp_r.ovf) begin
          mismatch_count++;
          $display("%0t: overflowed expected %0b actual %0b", $time, exp_r.ovf,
                   overflowed);
        end
      end
    end
  end

  initial begin
    while (cycle_count < LIMIT_CYCLES) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("timeout after %0d cycles, %0d results outstanding", cycle_count,
             sorted_q.size());
    $display("Mismatches found");
    $finish;
  end

  initial begin
    sort_result_t typed_r;
    int           row;
    int           rep;
    int           sent;
    int           size;
    int           k;
    logic         close;
    repeat (5) @(posedge clk);
    rst <= 1'b0;

    for (row = 0; row < DIR_ROWS; row++) begin
      for (rep = 0; rep < int'(directed_rows[row].reps); rep++) begin
        close = directed_rows[row].last && (rep == int'(directed_rows[row].reps) - 1);
        send_value(directed_rows[row].val, close);
        if (directed_rows[row].typed) begin
          typed_r.val  = directed_rows[row].want;
          typed_r.last = 1'b1;
          typed_r.ovf  = 1'b0;
          sorted_q.push_back(typed_r);
        end else begin
          predict_sorted(directed_rows[row].val, close);
        end
      end
    end

    sent = 0;
    while (sent < RAND_ITEMS) begin
      case (sent * 4 / RAND_ITEMS)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 75; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 75; end
        default: begin send_idle_pct = 11; recv_stall_pct = 11; end
      endcase
      // mostly short batches; full and overflowing ones now and then
      case ($urandom_range(9))
        0, 1, 2, 3, 4: size = $urandom_range(8, 1);
        5, 6, 7: size = $urandom_range(63, 9);
        8: size = MAX_ITEMS;
        default: size = $urandom_range(MAX_ITEMS + 8, MAX_ITEMS + 1);
      endcase
      for (k = 0; k < size; k++) begin
        value_pick: begin
          logic [VALUE_BITS-1:0] v;
          v = pick_value();
          send_value(v, k == size - 1);
          predict_sorted(v, k == size - 1);
        end
        sent++;
      end
    end
    in_valid <= 1'b0;

    while (sorted_q.size() != 0) @(posedge clk);
    repeat (30) @(posedge clk);
    if (mismatch_count == 0)
      $display("No mismatches found");
    else
      $display("Mismatches found");
    $finish;
  end

endmodule

// File: filelist.f
sv/bums_pkg.sv
sv/bums_datapath.sv
sv/bums_ctrl.sv
sv/bottom_up_merge_sort.sv
sim/tb_bottom_up_merge_sort.sv
